@@ hdl/brc_pkg.sv @@
// Shared types, constants and helpers for the block region classifier.
// Used by brc_front, brc_fifo, brc_back, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

	localparam int TILE_SIZE        = 16;
	localparam int TILE_BITS        = $clog2(TILE_SIZE);
	localparam int MAX_WIDTH        = 4096;
	localparam int MAX_HEIGHT       = 4096;
	localparam int MAX_TILES_ACROSS = 256;
	localparam int WIDTH_CAP        = (MAX_TILES_ACROSS * TILE_SIZE < MAX_WIDTH) ?
		MAX_TILES_ACROSS * TILE_SIZE : MAX_WIDTH;

	localparam int DIM_BITS   = 13;
	localparam int POS_BITS   = 12;
	localparam int TX_BITS    = 8;
	localparam int TY_BITS    = POS_BITS - TILE_BITS;
	localparam int SEG_BITS   = TILE_BITS + 1;
	localparam int CNT_BITS   = 9;
	localparam int FRAC_BITS  = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int PROD_BITS  = FRAC_BITS + CNT_BITS;
	localparam int DATA_BITS  = 17;
	localparam int INDEX_BITS = 3;

	localparam logic [7:0] MASK_ON = 8'd255;

	localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_MIN_DOMINANT = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_STRONG_PAIR  = 3'd3;

	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_FLAT   = 2'd1;
	localparam logic [1:0] CLS_MID    = 2'd2;
	localparam logic [1:0] CLS_DETAIL = 2'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR   = $clog2(FIFO_DEPTH);

	// one finished row segment of a tile
	typedef struct packed {
		logic [TX_BITS-1:0]  tx;
		logic [TY_BITS-1:0]  ty;
		logic [SEG_BITS-1:0] flat_cnt;
		logic [SEG_BITS-1:0] mid_cnt;
		logic [SEG_BITS-1:0] detail_cnt;
		logic [SEG_BITS-1:0] tw;
		logic [SEG_BITS-1:0] th;
		logic                end_y;
		logic                last;
	} seg_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] dominant;
		logic [FRAC_BITS-1:0] pair;
	} frac_cfg_t;

	// count * 2^16 >= frac * area
	function automatic logic reaches(input logic [CNT_BITS-1:0] cnt,
			input logic [PROD_BITS-1:0] prod);
		logic [PROD_BITS-1:0] scaled;
		scaled = PROD_BITS'({cnt, {FRAC_SHIFT{1'b0}}});
		return scaled >= prod;
	endfunction

endpackage

`default_nettype wire

@@ hdl/brc_front.sv @@
// Front part: tracks the raster position, tests the mask bytes and sums
// each tile row segment. Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         restart,
	input  wire logic [brc_pkg::DIM_BITS-1:0] width,
	input  wire logic [brc_pkg::DIM_BITS-1:0] height,
	input  wire logic                         push,
	input  wire logic                         fifo_full,
	input  wire logic [7:0]                   flat_byte,
	input  wire logic [7:0]                   mid_byte,
	input  wire logic [7:0]                   detail_byte,
	output logic                              seg_push,
	output brc_pkg::seg_t                     seg
);

	logic [brc_pkg::POS_BITS-1:0] col_q, row_q;
	logic [brc_pkg::SEG_BITS-1:0] acc_flat_q, acc_mid_q, acc_detail_q;
	logic [brc_pkg::SEG_BITS-1:0] sum_flat, sum_mid, sum_detail;
	logic [brc_pkg::DIM_BITS-1:0] col_inc, row_inc;
	logic                         accept, end_x, end_y, row_end, last_row;

	assign accept   = push && !fifo_full;
	assign col_inc  = {1'b0, col_q} + brc_pkg::DIM_BITS'(1);
	assign row_inc  = {1'b0, row_q} + brc_pkg::DIM_BITS'(1);
	assign row_end  = col_inc == width;
	assign last_row = row_inc == height;
	assign end_x    = (&col_q[brc_pkg::TILE_BITS-1:0]) || row_end;
	assign end_y    = (&row_q[brc_pkg::TILE_BITS-1:0]) || last_row;

	assign sum_flat   = acc_flat_q + brc_pkg::SEG_BITS'(flat_byte == brc_pkg::MASK_ON);
	assign sum_mid    = acc_mid_q + brc_pkg::SEG_BITS'(mid_byte == brc_pkg::MASK_ON);
	assign sum_detail = acc_detail_q + brc_pkg::SEG_BITS'(detail_byte == brc_pkg::MASK_ON);

	assign seg_push = accept && end_x;

	always_comb begin
		seg.tx         = col_q[brc_pkg::POS_BITS-1:brc_pkg::TILE_BITS];
		seg.ty         = row_q[brc_pkg::POS_BITS-1:brc_pkg::TILE_BITS];
		seg.flat_cnt   = sum_flat;
		seg.mid_cnt    = sum_mid;
		seg.detail_cnt = sum_detail;
		seg.tw         = brc_pkg::SEG_BITS'(col_q[brc_pkg::TILE_BITS-1:0]) +
			brc_pkg::SEG_BITS'(1);
		seg.th         = brc_pkg::SEG_BITS'(row_q[brc_pkg::TILE_BITS-1:0]) +
			brc_pkg::SEG_BITS'(1);
		seg.end_y      = end_y;
		seg.last       = row_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			acc_flat_q   <= '0;
			acc_mid_q    <= '0;
			acc_detail_q <= '0;
		end else if (restart) begin
			col_q        <= '0;
			row_q        <= '0;
			acc_flat_q   <= '0;
			acc_mid_q    <= '0;
			acc_detail_q <= '0;
		end else if (accept) begin
			// segment sums restart after each tile column boundary
			acc_flat_q   <= end_x ? '0 : sum_flat;
			acc_mid_q    <= end_x ? '0 : sum_mid;
			acc_detail_q <= end_x ? '0 : sum_detail;
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[brc_pkg::POS_BITS-1:0];
			end else begin
				col_q <= col_inc[brc_pkg::POS_BITS-1:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/brc_fifo.sv @@
// Short queue of row segments between the front and back parts.
// Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire brc_pkg::seg_t din,
	output logic               full,
	input  wire logic          rd_en,
	output brc_pkg::seg_t      dout,
	output logic               empty
);

	brc_pkg::seg_t                entry_q [brc_pkg::FIFO_DEPTH];
	logic [brc_pkg::FIFO_PTR-1:0] wr_ptr_q, rd_ptr_q;
	logic [brc_pkg::FIFO_PTR:0]   count_q;
	logic                         do_wr, do_rd;

	assign full  = count_q == (brc_pkg::FIFO_PTR + 1)'(brc_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + brc_pkg::FIFO_PTR'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + brc_pkg::FIFO_PTR'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (brc_pkg::FIFO_PTR + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (brc_pkg::FIFO_PTR + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/brc_back.sv @@
// Back part: adds row segments into the per tile column counter memory,
// classifies finished tiles and holds the result. Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire brc_pkg::frac_cfg_t            frac_cfg,
	input  wire logic                          fifo_empty,
	input  wire brc_pkg::seg_t                 head,
	output logic                               fifo_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [7:0]                         tile_column,
	output logic [7:0]                         tile_row,
	output logic [1:0]                         tile_class,
	output logic [brc_pkg::CNT_BITS-1:0]       flat_total,
	output logic [brc_pkg::CNT_BITS-1:0]       mid_total,
	output logic [brc_pkg::CNT_BITS-1:0]       detail_total,
	output logic [brc_pkg::CNT_BITS-1:0]       tile_area,
	output logic                               last_tile
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SUM   = 2'd1;
	localparam logic [1:0] ST_CLASS = 2'd2;
	localparam int ENTRY_BITS = 3 * brc_pkg::CNT_BITS;
	localparam int ENTRIES    = brc_pkg::MAX_TILES_ACROSS;

	logic [1:0]                    state_q;
	brc_pkg::seg_t                 cur_q;
	logic [brc_pkg::CNT_BITS-1:0]  area_q;
	logic [ENTRY_BITS-1:0]         mem [ENTRIES];
	logic [ENTRY_BITS-1:0]         rd_data_q;
	logic                          rd_valid_q;
	logic [ENTRIES-1:0]            valid_q;
	logic [brc_pkg::CNT_BITS-1:0]  sum_flat, sum_mid, sum_detail;
	logic [brc_pkg::CNT_BITS-1:0]  old_flat, old_mid, old_detail;
	logic [brc_pkg::CNT_BITS-1:0]  tot_flat_q, tot_mid_q, tot_detail_q;
	logic [brc_pkg::PROD_BITS-1:0] prod_dom_q, prod_pair_q;
	logic                          mem_we, out_valid_q, load_out;
	logic                          pair_hit, best_ok;
	logic [1:0]                    best_cls;
	logic [brc_pkg::CNT_BITS-1:0]  best_cnt;

	assign fifo_pop = (state_q == ST_IDLE) && !fifo_empty;
	assign mem_we   = (state_q == ST_SUM) && !cur_q.end_y;
	assign load_out = (state_q == ST_CLASS) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// an entry that was never written since reset or restart reads as zero
	assign old_flat   = rd_valid_q ? rd_data_q[3*brc_pkg::CNT_BITS-1:2*brc_pkg::CNT_BITS] : '0;
	assign old_mid    = rd_valid_q ? rd_data_q[2*brc_pkg::CNT_BITS-1:brc_pkg::CNT_BITS] : '0;
	assign old_detail = rd_valid_q ? rd_data_q[brc_pkg::CNT_BITS-1:0] : '0;

	assign sum_flat   = old_flat + brc_pkg::CNT_BITS'(cur_q.flat_cnt);
	assign sum_mid    = old_mid + brc_pkg::CNT_BITS'(cur_q.mid_cnt);
	assign sum_detail = old_detail + brc_pkg::CNT_BITS'(cur_q.detail_cnt);

	always_comb begin
		pair_hit = brc_pkg::reaches(tot_flat_q, prod_pair_q) &&
			brc_pkg::reaches(tot_detail_q, prod_pair_q) &&
			!brc_pkg::reaches(tot_mid_q, prod_pair_q);
		best_cnt = tot_flat_q;
		best_cls = brc_pkg::CLS_FLAT;
		if (tot_mid_q > best_cnt) begin
			best_cnt = tot_mid_q;
			best_cls = brc_pkg::CLS_MID;
		end
		if (tot_detail_q > best_cnt) begin
			best_cnt = tot_detail_q;
			best_cls = brc_pkg::CLS_DETAIL;
		end
		best_ok = brc_pkg::reaches(best_cnt, prod_dom_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_q.tx] <= {sum_flat, sum_mid, sum_detail};
		end
		if (fifo_pop) begin
			rd_data_q <= mem[head.tx];
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cur_q      <= head;
			area_q     <= brc_pkg::CNT_BITS'(head.tw) * brc_pkg::CNT_BITS'(head.th);
			rd_valid_q <= valid_q[head.tx];
		end
		if (state_q == ST_SUM) begin
			tot_flat_q   <= sum_flat;
			tot_mid_q    <= sum_mid;
			tot_detail_q <= sum_detail;
			prod_dom_q   <= brc_pkg::PROD_BITS'(frac_cfg.dominant) *
				brc_pkg::PROD_BITS'(area_q);
			prod_pair_q  <= brc_pkg::PROD_BITS'(frac_cfg.pair) *
				brc_pkg::PROD_BITS'(area_q);
		end
		if (load_out) begin
			tile_column  <= cur_q.tx;
			tile_row     <= cur_q.ty;
			tile_class   <= pair_hit ? brc_pkg::CLS_MID :
				(best_ok ? best_cls : brc_pkg::CLS_NONE);
			flat_total   <= tot_flat_q;
			mid_total    <= tot_mid_q;
			detail_total <= tot_detail_q;
			tile_area    <= area_q;
			last_tile    <= cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (restart) begin
			valid_q <= '0;
		end else if (state_q == ST_SUM) begin
			// a finished tile leaves its column empty for the next tile row
			valid_q[cur_q.tx] <= !cur_q.end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fifo_pop) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= cur_q.end_y ? ST_CLASS : ST_IDLE;
				end
				ST_CLASS: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/block_region_classifier.sv @@
// Top level of the block region classifier: configuration registers and
// the front, queue and back parts. Depends on brc_pkg, brc_front, brc_fifo and brc_back.
//
//  channel   handshake        payload
//  -------   ---------------  ------------------------------------------------
//  pixel     push / full      flat_byte, mid_byte, detail_byte
//  tile      empty / pop      tile_column, tile_row, tile_class, flat_total,
//                             mid_total, detail_total, tile_area, last_tile
//  config    wr_en            wr_index, wr_data
//
// The front takes one pixel per cycle. Each tile row segment goes through a
// four entry queue to the back, which does a counter memory read-modify-write
// per segment and classifies a tile after its last row. Segments of 16 pixels
// keep one pixel per cycle while results are popped; very narrow images stall
// push via full. Reset and a width or height write clear the counter valid
// bits at once, with no clearing pass. A result waits on the ports until pop.
`timescale 1ns / 1ps
`default_nettype none

module block_region_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [7:0]                     flat_byte,
	input  wire logic [7:0]                     mid_byte,
	input  wire logic [7:0]                     detail_byte,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [7:0]                          tile_column,
	output logic [7:0]                          tile_row,
	output logic [1:0]                          tile_class,
	output logic [8:0]                          flat_total,
	output logic [8:0]                          mid_total,
	output logic [8:0]                          detail_total,
	output logic [8:0]                          tile_area,
	output logic                                last_tile,
	input  wire logic                           wr_en,
	input  wire logic [brc_pkg::INDEX_BITS-1:0] wr_index,
	input  wire logic [brc_pkg::DATA_BITS-1:0]  wr_data
);

	logic [brc_pkg::DIM_BITS-1:0]  width_q, height_q, eff_width, eff_height;
	logic [brc_pkg::FRAC_BITS-1:0] dominant_q, pair_q;
	logic                          restart, seg_push, fifo_empty, fifo_pop;
	brc_pkg::seg_t                 seg, head;
	brc_pkg::frac_cfg_t            frac_cfg;

	assign restart = wr_en && (wr_index == brc_pkg::REG_IMAGE_WIDTH ||
		wr_index == brc_pkg::REG_IMAGE_HEIGHT);

	always_comb begin
		if (width_q == '0) begin
			eff_width = brc_pkg::DIM_BITS'(1);
		end else if (width_q > brc_pkg::DIM_BITS'(brc_pkg::WIDTH_CAP)) begin
			eff_width = brc_pkg::DIM_BITS'(brc_pkg::WIDTH_CAP);
		end else begin
			eff_width = width_q;
		end
		if (height_q == '0) begin
			eff_height = brc_pkg::DIM_BITS'(1);
		end else if (height_q > brc_pkg::DIM_BITS'(brc_pkg::MAX_HEIGHT)) begin
			eff_height = brc_pkg::DIM_BITS'(brc_pkg::MAX_HEIGHT);
		end else begin
			eff_height = height_q;
		end
		frac_cfg.dominant = dominant_q;
		frac_cfg.pair     = pair_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= brc_pkg::DIM_BITS'(640);
			height_q   <= brc_pkg::DIM_BITS'(480);
			dominant_q <= brc_pkg::FRAC_BITS'(32768);
			pair_q     <= brc_pkg::FRAC_BITS'(19661);
		end else if (wr_en) begin
			unique case (wr_index)
				brc_pkg::REG_IMAGE_WIDTH:  width_q    <= wr_data[brc_pkg::DIM_BITS-1:0];
				brc_pkg::REG_IMAGE_HEIGHT: height_q   <= wr_data[brc_pkg::DIM_BITS-1:0];
				brc_pkg::REG_MIN_DOMINANT: dominant_q <= wr_data[brc_pkg::FRAC_BITS-1:0];
				brc_pkg::REG_STRONG_PAIR:  pair_q     <= wr_data[brc_pkg::FRAC_BITS-1:0];
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	brc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.width       (eff_width),
		.height      (eff_height),
		.push        (push),
		.fifo_full   (full),
		.flat_byte   (flat_byte),
		.mid_byte    (mid_byte),
		.detail_byte (detail_byte),
		.seg_push    (seg_push),
		.seg         (seg)
	);

	brc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (seg_push),
		.din    (seg),
		.full   (full),
		.rd_en  (fifo_pop),
		.dout   (head),
		.empty  (fifo_empty)
	);

	brc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.frac_cfg     (frac_cfg),
		.fifo_empty   (fifo_empty),
		.head         (head),
		.fifo_pop     (fifo_pop),
		.empty        (empty),
		.pop          (pop),
		.tile_column  (tile_column),
		.tile_row     (tile_row),
		.tile_class   (tile_class),
		.flat_total   (flat_total),
		.mid_total    (mid_total),
		.detail_total (detail_total),
		.tile_area    (tile_area),
		.last_tile    (last_tile)
	);

endmodule

`default_nettype wire

@@ hdl/brc_checker.sv @@
// Port level checks for the block region classifier, bound to the top level.
// Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] tile_column,
	input wire logic [7:0] tile_row,
	input wire logic [1:0] tile_class,
	input wire logic [8:0] flat_total,
	input wire logic [8:0] mid_total,
	input wire logic [8:0] detail_total,
	input wire logic [8:0] tile_area,
	input wire logic       last_tile
);

	// a waiting tile holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(tile_column) && $stable(tile_row) &&
			$stable(tile_class) && $stable(last_tile))
		else $error("tile item changed while waiting");

	a_area: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> tile_area != 9'd0 && tile_area <= 9'd256)
		else $error("tile area out of range");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> flat_total <= tile_area && mid_total <= tile_area &&
			detail_total <= tile_area)
		else $error("class total exceeds tile area");

	// flat only wins as the largest count
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && tile_class == brc_pkg::CLS_FLAT |->
			flat_total >= mid_total && flat_total >= detail_total)
		else $error("flat class without the largest count");

endmodule

bind block_region_classifier brc_checker u_brc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.tile_column  (tile_column),
	.tile_row     (tile_row),
	.tile_class   (tile_class),
	.flat_total   (flat_total),
	.mid_total    (mid_total),
	.detail_total (detail_total),
	.tile_area    (tile_area),
	.last_tile    (last_tile)
);

`default_nettype wire

@@ verif/block_region_classifier_tb.sv @@
// Self-checking testbench for block_region_classifier: a scoreboard class keeps
// its own copy of the tile counters and registers and predicts each tile result.
// Depends on brc_pkg and the block_region_classifier RTL.
`timescale 1ns / 1ps

module block_region_classifier_tb;

	localparam int RANDOM_ITEMS    = 450;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int PHASE_CAP       = 600;

	localparam logic [brc_pkg::INDEX_BITS-1:0] REG_UNMAPPED  =
		brc_pkg::REG_STRONG_PAIR + 1'b1;
	localparam logic [brc_pkg::INDEX_BITS-1:0] REG_INDEX_TOP = '1;

	typedef struct packed {
		logic [7:0] tile_column;
		logic [7:0] tile_row;
		logic [1:0] tile_class;
		logic [8:0] flat_total;
		logic [8:0] mid_total;
		logic [8:0] detail_total;
		logic [8:0] tile_area;
		logic       last_tile;
	} tile_result_t;

	class tile_scoreboard;
		logic [brc_pkg::DIM_BITS-1:0]  width_reg;
		logic [brc_pkg::DIM_BITS-1:0]  height_reg;
		logic [brc_pkg::FRAC_BITS-1:0] dominant_reg;
		logic [brc_pkg::FRAC_BITS-1:0] pair_reg;
		int unsigned          col_pos;
		int unsigned          row_pos;
		int unsigned          flat_sum[brc_pkg::MAX_TILES_ACROSS];
		int unsigned          mid_sum[brc_pkg::MAX_TILES_ACROSS];
		int unsigned          detail_sum[brc_pkg::MAX_TILES_ACROSS];
		tile_result_t         expected_tiles[$];
		int unsigned          errors;

		function new();
			width_reg       = 13'd640;
			height_reg      = 13'd480;
			dominant_reg    = 17'd32768;
			pair_reg        = 17'd19661;
			errors          = 0;
			restart();
		endfunction

		function void restart();
			col_pos = 0;
			row_pos = 0;
			foreach (flat_sum[i]) begin
				flat_sum[i]   = 0;
				mid_sum[i]    = 0;
				detail_sum[i] = 0;
			end
		endfunction

		function void write_reg(logic [brc_pkg::INDEX_BITS-1:0] index,
				logic [brc_pkg::DATA_BITS-1:0] data);
			case (index)
				brc_pkg::REG_IMAGE_WIDTH: begin
					width_reg = data[brc_pkg::DIM_BITS-1:0];
					restart();
				end
				brc_pkg::REG_IMAGE_HEIGHT: begin
					height_reg = data[brc_pkg::DIM_BITS-1:0];
					restart();
				end
				brc_pkg::REG_MIN_DOMINANT: dominant_reg = data[brc_pkg::FRAC_BITS-1:0];
				brc_pkg::REG_STRONG_PAIR:  pair_reg = data[brc_pkg::FRAC_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_width();
			int unsigned w;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > brc_pkg::WIDTH_CAP) w = brc_pkg::WIDTH_CAP;
			return w;
		endfunction

		function int unsigned active_height();
			int unsigned h;
			h = height_reg;
			if (h == 0) h = 1;
			if (h > brc_pkg::MAX_HEIGHT) h = brc_pkg::MAX_HEIGHT;
			return h;
		endfunction

		// count * 2^16 >= frac * area, without overflow
		function bit share_reached(int unsigned cnt, logic [brc_pkg::FRAC_BITS-1:0] frac,
				int unsigned area);
			longint unsigned lhs;
			longint unsigned rhs;
			lhs = cnt;
			lhs = lhs << brc_pkg::FRAC_SHIFT;
			rhs = frac;
			rhs = rhs * area;
			return lhs >= rhs;
		endfunction

		function logic [1:0] classify(int unsigned f, m, d, area);
			int unsigned best;
			logic [1:0]  cls;
			if (share_reached(f, pair_reg, area) && share_reached(d, pair_reg, area) &&
					!share_reached(m, pair_reg, area))
				return brc_pkg::CLS_MID;
			best = f;
			cls  = brc_pkg::CLS_FLAT;
			if (m > best) begin
				best = m;
				cls  = brc_pkg::CLS_MID;
			end
			if (d > best) begin
				best = d;
				cls  = brc_pkg::CLS_DETAIL;
			end
			return share_reached(best, dominant_reg, area) ? cls : brc_pkg::CLS_NONE;
		endfunction

		function void note_pixel(logic [7:0] f, logic [7:0] m, logic [7:0] d);
			int unsigned  w, h, x, y, tx, ty, tw, th, area;
			bit           end_x, end_y;
			tile_result_t t;
			w = active_width();
			h = active_height();
			if (col_pos >= w) col_pos = 0;
			if (row_pos >= h) row_pos = 0;
			x  = col_pos;
			y  = row_pos;
			tx = x / brc_pkg::TILE_SIZE;
			ty = y / brc_pkg::TILE_SIZE;
			if (tx >= brc_pkg::MAX_TILES_ACROSS) tx = brc_pkg::MAX_TILES_ACROSS - 1;
			if (f == brc_pkg::MASK_ON) flat_sum[tx]++;
			if (m == brc_pkg::MASK_ON) mid_sum[tx]++;
			if (d == brc_pkg::MASK_ON) detail_sum[tx]++;
			end_x = ((x + 1) % brc_pkg::TILE_SIZE == 0) || (x + 1 == w);
			end_y = ((y + 1) % brc_pkg::TILE_SIZE == 0) || (y + 1 == h);
			if (end_x && end_y) begin
				tw = w - tx * brc_pkg::TILE_SIZE;
				if (tw > brc_pkg::TILE_SIZE) tw = brc_pkg::TILE_SIZE;
				th = h - ty * brc_pkg::TILE_SIZE;
				if (th > brc_pkg::TILE_SIZE) th = brc_pkg::TILE_SIZE;
				area = tw * th;
				t.tile_column  = tx[7:0];
				t.tile_row     = ty[7:0];
				t.tile_class   = classify(flat_sum[tx], mid_sum[tx], detail_sum[tx], area);
				t.flat_total   = flat_sum[tx][8:0];
				t.mid_total    = mid_sum[tx][8:0];
				t.detail_total = detail_sum[tx][8:0];
				t.tile_area    = area[8:0];
				t.last_tile    = (x + 1 == w) && (y + 1 == h);
				expected_tiles.push_back(t);
				flat_sum[tx]   = 0;
				mid_sum[tx]    = 0;
				detail_sum[tx] = 0;
			end
			if (x + 1 >= w) begin
				col_pos = 0;
				row_pos = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				col_pos = x + 1;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: ERROR %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_tile(tile_result_t got);
			tile_result_t want;
			if (expected_tiles.size() == 0) begin
				$display("%0t: ERROR tile result with none expected: column %0d row %0d",
					$time, got.tile_column, got.tile_row);
				errors++;
				return;
			end
			want = expected_tiles.pop_front();
			compare_field("tile_column", want.tile_column, got.tile_column);
			compare_field("tile_row", want.tile_row, got.tile_row);
			compare_field("tile_class", want.tile_class, got.tile_class);
			compare_field("flat_total", want.flat_total, got.flat_total);
			compare_field("mid_total", want.mid_total, got.mid_total);
			compare_field("detail_total", want.detail_total, got.detail_total);
			compare_field("tile_area", want.tile_area, got.tile_area);
			compare_field("last_tile", want.last_tile, got.last_tile);
		endfunction

		function int unsigned pending();
			return expected_tiles.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [7:0]                     flat_byte;
	logic [7:0]                     mid_byte;
	logic [7:0]                     detail_byte;
	logic                           empty;
	logic                           pop;
	logic [7:0]                     tile_column;
	logic [7:0]                     tile_row;
	logic [1:0]                     tile_class;
	logic [8:0]                     flat_total;
	logic [8:0]                     mid_total;
	logic [8:0]                     detail_total;
	logic [8:0]                     tile_area;
	logic                           last_tile;
	logic                           wr_en;
	logic [brc_pkg::INDEX_BITS-1:0] wr_index;
	logic [brc_pkg::DATA_BITS-1:0]  wr_data;

	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	bit             hold_off_req;
	int unsigned    random_items;
	tile_scoreboard tiles = new();

	block_region_classifier u_top (.*);

	always #10 clk = ~clk;

	// share of pixels that carry a class: often none or all, to force ties
	function automatic int unsigned pick_share();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 100;
			default: return $urandom_range(0, 100);
		endcase
	endfunction

	function automatic logic [7:0] mask_byte(int unsigned share);
		if ($urandom_range(0, 99) < share) return brc_pkg::MASK_ON;
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return brc_pkg::MASK_ON - 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [brc_pkg::DATA_BITS-1:0] random_fraction();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			3: return 17'd32768;
			4: return 17'($urandom_range(0, 30000));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] f, input logic [7:0] m, input logic [7:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		flat_byte   <= f;
		mid_byte    <= m;
		detail_byte <= d;
		do
			@(posedge clk);
		while (full);
		tiles.note_pixel(f, m, d);
	endtask

	task automatic write_reg(input logic [brc_pkg::INDEX_BITS-1:0] index,
			input logic [brc_pkg::DATA_BITS-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= data;
		@(posedge clk);
		tiles.write_reg(index, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// drop push, drain every expected tile, then let trailing segments settle
	task automatic wait_idle();
		int unsigned guard;
		push  <= 1'b0;
		guard = 0;
		while (tiles.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		int unsigned  hold_left;
		tile_result_t got;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got = {tile_column, tile_row, tile_class, flat_total, mid_total,
					detail_total, tile_area, last_tile};
				tiles.check_tile(got);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int unsigned p_flat, p_mid, p_detail, total, count, pick, w, h;
		arst_n      <= 1'b0;
		push        <= 1'b0;
		flat_byte   <= 8'h00;
		mid_byte    <= 8'h00;
		detail_byte <= 8'h00;
		wr_en       <= 1'b0;
		wr_index    <= brc_pkg::REG_IMAGE_WIDTH;
		wr_data     <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req  = 1'b0;
		random_items  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimensions: a few pixels complete no tile
		send_pixel(brc_pkg::MASK_ON, 8'h00, brc_pkg::MASK_ON);
		send_pixel(8'h00, brc_pkg::MASK_ON, 8'h00);
		send_pixel(brc_pkg::MASK_ON, brc_pkg::MASK_ON, brc_pkg::MASK_ON);
		send_pixel(8'h7f, 8'h80, 8'h01);
		wait_idle();

		// one-pixel tiles against a stalled receiver, so the block fills up;
		// data bits above the register width drop off
		hold_off_req = 1'b1;
		write_reg(brc_pkg::REG_IMAGE_WIDTH, 17'h1_e001);
		write_reg(brc_pkg::REG_IMAGE_HEIGHT, 17'h0_0001);
		write_reg(REG_UNMAPPED, 17'h0_0000);
		write_reg(REG_INDEX_TOP, 17'h1_ffff);
		send_pixel(brc_pkg::MASK_ON, 8'h00, 8'h00);
		send_pixel(8'h00, brc_pkg::MASK_ON, 8'h00);
		send_pixel(8'h00, 8'h00, brc_pkg::MASK_ON);
		send_pixel(brc_pkg::MASK_ON, 8'h00, brc_pkg::MASK_ON);
		send_pixel(brc_pkg::MASK_ON, brc_pkg::MASK_ON, brc_pkg::MASK_ON);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hfe, 8'hfe, 8'hfe);
		send_pixel(8'h7f, 8'h80, 8'h01);
		send_pixel(brc_pkg::MASK_ON, brc_pkg::MASK_ON, 8'h00);
		send_pixel(8'h00, brc_pkg::MASK_ON, brc_pkg::MASK_ON);
		wait_idle();

		// pair share above one never passes
		write_reg(brc_pkg::REG_MIN_DOMINANT, 17'd65536);
		write_reg(brc_pkg::REG_STRONG_PAIR, 17'd65537);
		send_pixel(brc_pkg::MASK_ON, 8'h00, brc_pkg::MASK_ON);
		send_pixel(8'h00, 8'h00, brc_pkg::MASK_ON);
		wait_idle();
		write_reg(brc_pkg::REG_MIN_DOMINANT, 17'h1_ffff);
		send_pixel(brc_pkg::MASK_ON, 8'h00, 8'h00);
		wait_idle();

		// zero shares always pass
		write_reg(brc_pkg::REG_MIN_DOMINANT, 17'd0);
		write_reg(brc_pkg::REG_STRONG_PAIR, 17'd0);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, brc_pkg::MASK_ON, 8'h00);
		wait_idle();

		// zero dimensions act as one
		write_reg(brc_pkg::REG_IMAGE_WIDTH, 17'd0);
		write_reg(brc_pkg::REG_IMAGE_HEIGHT, 17'd0);
		send_pixel(brc_pkg::MASK_ON, brc_pkg::MASK_ON, brc_pkg::MASK_ON);
		wait_idle();

		// one clipped tile of 3x2
		write_reg(brc_pkg::REG_IMAGE_WIDTH, 17'd3);
		write_reg(brc_pkg::REG_IMAGE_HEIGHT, 17'd2);
		write_reg(brc_pkg::REG_MIN_DOMINANT, 17'd32768);
		write_reg(brc_pkg::REG_STRONG_PAIR, 17'd19661);
		send_pixel(brc_pkg::MASK_ON, 8'h00, brc_pkg::MASK_ON);
		send_pixel(brc_pkg::MASK_ON, 8'h00, 8'h00);
		send_pixel(8'h00, brc_pkg::MASK_ON, brc_pkg::MASK_ON);
		send_pixel(brc_pkg::MASK_ON, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, brc_pkg::MASK_ON);
		send_pixel(8'hfe, 8'h01, brc_pkg::MASK_ON);
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 54;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// most phases start a new image; the rest carry on mid-image
			if ($urandom_range(0, 99) < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 8);
				end else if (pick < 80) begin
					w = $urandom_range(1, 24);
					h = $urandom_range(1, 20);
				end else if (pick < 94) begin
					w = $urandom_range(14, 40);
					h = $urandom_range(14, 34);
				end else if (pick < 97) begin
					w = ($urandom_range(0, 1) != 0) ? 4097 : 8191;
					h = $urandom_range(0, 2);
				end else begin
					w = $urandom_range(0, 3);
					h = ($urandom_range(0, 1) != 0) ? 4096 : 8191;
				end
				write_reg(brc_pkg::REG_IMAGE_WIDTH, brc_pkg::DATA_BITS'(w));
				write_reg(brc_pkg::REG_IMAGE_HEIGHT, brc_pkg::DATA_BITS'(h));
			end
			if ($urandom_range(0, 1) != 0)
				write_reg(brc_pkg::REG_MIN_DOMINANT, random_fraction());
			if ($urandom_range(0, 1) != 0)
				write_reg(brc_pkg::REG_STRONG_PAIR, random_fraction());
			if ($urandom_range(0, 19) == 0)
				write_reg(REG_UNMAPPED + brc_pkg::INDEX_BITS'($urandom_range(0, 3)),
					brc_pkg::DATA_BITS'($urandom));

			total = tiles.active_width() * tiles.active_height();
			if ($urandom_range(0, 3) == 0)
				count = $urandom_range(1, total);
			else
				count = total * $urandom_range(1, 2);
			if (count > PHASE_CAP) count = $urandom_range(32, PHASE_CAP);
			// stop at the item budget
			if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;

			p_flat   = pick_share();
			p_mid    = pick_share();
			p_detail = pick_share();
			for (int unsigned i = 0; i < count; i++) begin
				// change the mix now and then so tiles within a phase differ
				if ($urandom_range(0, 63) == 0) begin
					p_flat   = pick_share();
					p_mid    = pick_share();
					p_detail = pick_share();
				end
				send_pixel(mask_byte(p_flat), mask_byte(p_mid), mask_byte(p_detail));
				random_items++;
			end
			wait_idle();
		end

		if (tiles.pending() != 0) begin
			$display("%0t: ERROR %0d expected tile results never arrived", $time,
				tiles.pending());
			tiles.errors++;
		end
		if (tiles.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/brc_pkg.sv
hdl/brc_front.sv
hdl/brc_fifo.sv
hdl/brc_back.sv
hdl/block_region_classifier.sv
hdl/brc_checker.sv
verif/block_region_classifier_tb.sv
